[rtl/core/periodic_priority_task_dispatcher_defines.svh]
// ----------------------------------------------------------------------------
// Task dispatcher assertion macros
// Shared concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PERIODIC_PRIORITY_TASK_DISPATCHER_DEFINES_SVH
`define PERIODIC_PRIORITY_TASK_DISPATCHER_DEFINES_SVH
`ifndef SYNTH
`define PPTD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("pptd assertion failed");
`define PPTD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("pptd check failed");
`else
`define PPTD_ASSERT(lbl, clk, rst, prop)
`define PPTD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

[rtl/core/pptd_pkg.sv]
// ----------------------------------------------------------------------------
// Task dispatcher package
// Sizes, codes and word types shared by the dispatcher files.
// ----------------------------------------------------------------------------
package pptd_pkg;

  localparam int MAX_TASKS    = 8;
  localparam int IDX_W        = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W        = $clog2(MAX_TASKS + 1);
  localparam int RESULT_LIMIT = 8;
  localparam int LIM_W        = $clog2(RESULT_LIMIT);
  localparam int QUEUE_DEPTH  = 2;

  typedef enum logic [2:0] {
    KIND_ADD    = 3'd0,
    KIND_REMOVE = 3'd1,
    KIND_ENABLE = 3'd2,
    KIND_TICK   = 3'd3,
    KIND_SCAN   = 3'd4,
    KIND_DONE   = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NONE_DUE  = 3'd4
  } status_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  task_id;
    logic [7:0]  priority_req;
    logic [31:0] period;
    logic        enable;
    logic [31:0] elapsed;
  } cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  dispatch_id;
    logic        overrun;
    logic [31:0] now_tick;
    logic [31:0] dispatch_total;
    logic [31:0] overrun_total;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  handle;
    logic [7:0]  prio;
    logic [31:0] period;
    logic [31:0] last_run;
    logic        enabled;
  } entry_t;

  // queue handshake between front and back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_t;

endpackage

[rtl/core/pptd_cmd_if.sv]
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel carrying one request word.
// ----------------------------------------------------------------------------
interface pptd_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  task_id;
  logic [7:0]  priority_req;
  logic [31:0] period;
  logic        enable;
  logic [31:0] elapsed;

  modport source (output valid, kind, task_id, priority_req, period, enable, elapsed,
                  input ready);
  modport sink (input valid, kind, task_id, priority_req, period, enable, elapsed,
                output ready);
endinterface

[rtl/core/pptd_rsp_if.sv]
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface pptd_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  dispatch_id;
  logic        overrun;
  logic [31:0] now_tick;
  logic [31:0] dispatch_total;
  logic [31:0] overrun_total;
  logic        last;

  modport source (output valid, status, dispatch_id, overrun, now_tick, dispatch_total,
                  overrun_total, last, input ready);
  modport sink (input valid, status, dispatch_id, overrun, now_tick, dispatch_total,
                overrun_total, last, output ready);
endinterface

[rtl/core/pptd_front.sv]
// ----------------------------------------------------------------------------
// Dispatcher front end
// Accepts request words, drops unknown kinds, queues the rest.
// ----------------------------------------------------------------------------
module pptd_front
  import pptd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  pptd_cmd_if.sink     cmd,
  input  logic         pop,
  output q_t           q
);

  localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr;
  logic [QP_W-1:0] rd_ptr;
  logic [QC_W-1:0] count;
  logic            push;
  logic            known;
  logic            do_pop;

  assign cmd.ready = (count != QC_W'(QUEUE_DEPTH));
  assign known     = (cmd.kind <= KIND_DONE);
  assign push      = cmd.valid && cmd.ready && known;
  assign do_pop    = pop && (count != '0);
  assign q.valid   = (count != '0);
  assign q.cmd     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= '{kind: cmd.kind, task_id: cmd.task_id,
                       priority_req: cmd.priority_req, period: cmd.period,
                       enable: cmd.enable, elapsed: cmd.elapsed};
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QC_W'(push) - QC_W'(do_pop);
    end
  end

endmodule

[rtl/core/pptd_back.sv]
// ----------------------------------------------------------------------------
// Dispatcher back end
// Task table, request execution, scan walk and result register.
// ----------------------------------------------------------------------------
`include "periodic_priority_task_dispatcher_defines.svh"

module pptd_back
  import pptd_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  q_t           q,
  output logic         pop,
  pptd_rsp_if.source   rsp
);

  typedef enum logic { S_IDLE, S_SCAN } state_t;

  state_t           state;
  entry_t           tbl [MAX_TASKS];
  entry_t           up  [MAX_TASKS];
  entry_t           dn  [MAX_TASKS];
  logic [CNT_W-1:0] used;
  logic [31:0]      uptime;
  logic [31:0]      dispatches;
  logic [31:0]      overruns;
  logic [IDX_W-1:0] idx;
  logic [LIM_W-1:0] n;
  logic             o_valid;
  rsp_t             o;

  logic [MAX_TASKS-1:0] live, hit, due;
  logic             found;
  logic [IDX_W-1:0] slot;
  logic [CNT_W-1:0] pos;
  logic             any_due, rest_due, out_free, scan_last, ovr_hit;
  entry_t           new_e;
  cmd_t             c;

  assign c        = q.cmd;
  assign out_free = !o_valid || rsp.ready;

  always_comb begin
    found    = 1'b0;
    slot     = '0;
    pos      = used;
    rest_due = 1'b0;
    for (int k = MAX_TASKS - 1; k >= 0; k--) begin
      live[k] = (CNT_W'(k) < used);
      hit[k]  = live[k] && (tbl[k].handle == c.task_id);
      due[k]  = live[k] && tbl[k].enabled &&
                ((tbl[k].period == '0) || ((uptime - tbl[k].last_run) >= tbl[k].period));
      if (hit[k]) begin
        found = 1'b1;
        slot  = IDX_W'(k);
      end
      if (live[k] && (c.priority_req < tbl[k].prio)) begin
        pos = CNT_W'(k);
      end
      if (due[k] && (IDX_W'(k) > idx)) begin
        rest_due = 1'b1;
      end
    end
    any_due   = |due;
    scan_last = (n == LIM_W'(RESULT_LIMIT - 1)) || !rest_due;
    ovr_hit   = (tbl[slot].period != '0) && (c.elapsed > tbl[slot].period);
    new_e     = '{handle: c.task_id, prio: c.priority_req, period: c.period,
                  last_run: uptime, enabled: c.enable};
    up[0] = tbl[0];
    dn[MAX_TASKS-1] = tbl[MAX_TASKS-1];
    for (int k = 1; k < MAX_TASKS; k++) begin
      up[k]   = tbl[k-1];
      dn[k-1] = tbl[k];
    end
  end

  assign pop = q.valid && (state == S_IDLE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      uptime     <= '0;
      dispatches <= '0;
      overruns   <= '0;
      o_valid    <= 1'b0;
      idx        <= '0;
      n          <= '0;
    end else begin
      if (rsp.ready) o_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            o_valid          <= 1'b1;
            o.status         <= ST_OK;
            o.dispatch_id    <= c.task_id;
            o.overrun        <= 1'b0;
            o.now_tick       <= uptime;
            o.dispatch_total <= dispatches;
            o.overrun_total  <= overruns;
            o.last           <= 1'b1;
            case (c.kind)
              KIND_ADD: begin
                if (used == CNT_W'(MAX_TASKS)) begin
                  o.status <= ST_FULL;
                end else if (found) begin
                  o.status <= ST_PRESENT;
                end else begin
                  for (int k = 0; k < MAX_TASKS; k++) begin
                    if (CNT_W'(k) == pos) tbl[k] <= new_e;
                    else if (CNT_W'(k) > pos && CNT_W'(k) <= used) tbl[k] <= up[k];
                  end
                  used <= used + 1'b1;
                end
              end
              KIND_REMOVE: begin
                if (!found) begin
                  o.status <= ST_NOT_FOUND;
                end else begin
                  for (int k = 0; k < MAX_TASKS; k++) begin
                    if (IDX_W'(k) >= slot) tbl[k] <= dn[k];
                  end
                  used <= used - 1'b1;
                end
              end
              KIND_ENABLE: begin
                if (!found) o.status <= ST_NOT_FOUND;
                else tbl[slot].enabled <= c.enable;
              end
              KIND_TICK: begin
                uptime        <= uptime + 1'b1;
                o.now_tick    <= uptime + 1'b1;
                o.dispatch_id <= '0;
              end
              KIND_SCAN: begin
                if (!any_due) begin
                  o.status      <= ST_NONE_DUE;
                  o.dispatch_id <= '0;
                end else begin
                  // results come from the walk
                  o_valid <= 1'b0;
                  state   <= S_SCAN;
                  idx     <= '0;
                  n       <= '0;
                end
              end
              KIND_DONE: begin
                if (!found) begin
                  o.status <= ST_NOT_FOUND;
                end else if (ovr_hit) begin
                  overruns        <= overruns + 1'b1;
                  o.overrun_total <= overruns + 1'b1;
                  o.overrun       <= 1'b1;
                end
              end
              default: o_valid <= 1'b0;
            endcase
          end
        end
        S_SCAN: begin
          if (!due[idx]) begin
            idx <= idx + 1'b1;
          end else if (out_free) begin
            tbl[idx].last_run <= uptime;
            dispatches       <= dispatches + 1'b1;
            o_valid          <= 1'b1;
            o.status         <= ST_OK;
            o.dispatch_id    <= tbl[idx].handle;
            o.overrun        <= 1'b0;
            o.now_tick       <= uptime;
            o.dispatch_total <= dispatches + 1'b1;
            o.overrun_total  <= overruns;
            o.last           <= scan_last;
            idx              <= idx + 1'b1;
            n                <= n + 1'b1;
            if (scan_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid          = o_valid;
  assign rsp.status         = o.status;
  assign rsp.dispatch_id    = o.dispatch_id;
  assign rsp.overrun        = o.overrun;
  assign rsp.now_tick       = o.now_tick;
  assign rsp.dispatch_total = o.dispatch_total;
  assign rsp.overrun_total  = o.overrun_total;
  assign rsp.last           = o.last;

  `PPTD_ASSERT(a_used_bound, clk, rst, used <= CNT_W'(MAX_TASKS))
  `PPTD_ASSERT(a_scan_has_due, clk, rst, (state == S_SCAN) |-> (any_due && used != '0))
  `PPTD_ASSERT(a_no_pop_in_scan, clk, rst, (state == S_SCAN) |-> !pop)
  `PPTD_ASSERT(a_disp_step, clk, rst,
    (state == S_SCAN && due[idx] && out_free) |=> (dispatches == $past(dispatches) + 1))

endmodule

[rtl/core/periodic_priority_task_dispatcher.sv]
// ----------------------------------------------------------------------------
// Periodic priority task dispatcher
// Priority-ordered periodic task table with add/remove/enable/tick/scan/done.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one request word per handshake (add, remove, set enable,
//   tick, scan, done). Unknown kinds are accepted and dropped.
//   rsp returns result words; a scan yields one word per dispatched task
//   (up to eight, last set on the final one) or a single none-due word.
// Request flow:
//   A request is taken into a two-word queue when offered while cmd.ready is high.
//   Non-scan requests are popped while the back end is idle and the result
//   register is free, execute in the back end and land in the result register.
//   A scan walks the table one entry per cycle, holding on a due entry while
//   the result is stalled; no new request is popped until the scan ends.
// Reset:
//   Synchronous rst empties the table, the queue and the result register
//   and clears uptime and both totals. No clearing pass is needed.
// Backpressure:
//   When rsp stalls the result register holds; the back end stops and the
//   queue fills, after which cmd.ready drops.
// ----------------------------------------------------------------------------
module periodic_priority_task_dispatcher
  import pptd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  pptd_cmd_if.sink   cmd,
  pptd_rsp_if.source rsp
);

  q_t   q;
  logic pop;

  // front: accept and queue
  pptd_front u_front (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .pop (pop),
    .q   (q)
  );

  // back: table and result generation
  pptd_back u_back (
    .clk (clk),
    .rst (rst),
    .q   (q),
    .pop (pop),
    .rsp (rsp)
  );

endmodule
